// ===== rtl/kabf_pkg.sv =====
`default_nettype none
package kabf_pkg;

  localparam int unsigned COV_W = 48;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OPD_W = 49;
  localparam int unsigned SUM_W = 52;

  localparam logic [31:0] ANGLE_NOISE_RST   = 32'd4294967;
  localparam logic [31:0] BIAS_NOISE_RST    = 32'd12884902;
  localparam logic [31:0] MEASURE_NOISE_RST = 32'd128849019;

  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  typedef enum logic [3:0] {
    OP_ANG_P,
    OP_T,
    OP_INNER,
    OP_P00,
    OP_P11,
    OP_S,
    OP_K0,
    OP_K1,
    OP_ANG_C,
    OP_BIAS_C,
    OP_N0,
    OP_P10C,
    OP_P11C,
    OP_P01C
  } op_t;

  typedef enum logic [1:0] {
    KIND_MUL,
    KIND_DIV,
    KIND_ALU
  } kind_t;

  typedef struct packed {
    logic load;
    logic start_mul;
    logic start_div;
    logic write;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic singular;
  } stat_t;

  function automatic kind_t op_kind(input op_t op);
    kind_t k;
    case (op)
      OP_INNER, OP_S: k = KIND_ALU;
      OP_K0, OP_K1:   k = KIND_DIV;
      default:        k = KIND_MUL;
    endcase
    return k;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext48(input logic signed [COV_W-1:0] v);
    return {{(SUM_W-COV_W){v[COV_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext32(input logic signed [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [COV_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [COV_W-1:0] r;
    if (v > 52'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < 52'shF_8000_0000_0000) r = 48'sh8000_0000_0000;
    else r = v[COV_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 52'sh0_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < 52'shF_FFFF_8000_0000) r = 32'sh8000_0000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

  function automatic logic [COV_W-1:0] mag49(input logic signed [OPD_W-1:0] v);
    logic signed [OPD_W-1:0] n;
    n = -v;
    return v[OPD_W-1] ? n[COV_W-1:0] : v[COV_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kalman_angle_bias_filter.sv =====
// Channel | Direction | Contents
// in_     | slave     | tdata: meas_angle, gyro_rate, time_step
// out_    | master    | tdata: filtered_angle, rate_bias; tuser: singular_flag
// cfg_    | write     | angle_noise, bias_noise, measure_noise
//
// An item is worked through before the next input is taken: ten products on one
// shared 32x32 multiplier and two gains from a radix-2 divider. A singular item
// skips the divider.
// Reset is synchronous, clears estimates and covariance and loads the noise defaults.
// A waiting result does not stop the next input transfer, only the result after it.
`default_nettype none
module kalman_angle_bias_filter
  import kabf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // meas_angle, gyro_rate, time_step
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // filtered_angle, rate_bias
  output logic [0:0]       out_tuser,  // singular_flag
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  kabf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  kabf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/kabf_mul.sv =====
`default_nettype none
module kabf_mul
  import kabf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [COV_W-1:0]        a_mag,
  input  wire logic [COV_W-1:0]        b_mag,
  input  wire logic                    neg,
  input  wire logic                    sh32,
  output logic                         done,
  output logic signed [COV_W-1:0]      result
);

  logic [COV_W-1:0] a_r, b_r;
  logic             neg_r, sh32_r;
  logic [95:0]      acc_r, acc_nxt;
  logic [63:0]      pp_r;
  logic [1:0]       off_r;
  logic [2:0]       ph_r;
  logic             busy_r, done_r;
  logic signed [COV_W-1:0] res_r, res_nxt;
  logic [31:0]      a_part, b_part;
  logic [95:0]      pp_sh;
  logic [71:0]      q, lim, qs;

  always_comb begin
    a_part = ph_r[1] ? {16'b0, a_r[47:32]} : a_r[31:0];
    b_part = ph_r[0] ? {16'b0, b_r[47:32]} : b_r[31:0];
    case (off_r)
      2'd0:    pp_sh = {32'b0, pp_r};
      2'd1:    pp_sh = {pp_r, 32'b0};
      default: pp_sh = {pp_r[31:0], 64'b0};
    endcase
    acc_nxt = acc_r;
    if (ph_r >= 3'd1 && ph_r <= 3'd4) begin
      acc_nxt = acc_r + pp_sh;
    end else if (ph_r == 3'd5) begin
      acc_nxt = acc_r + (sh32_r ? (96'd1 << 31) : (96'd1 << 23));
    end
    q = sh32_r ? {8'b0, acc_r[95:32]} : acc_r[95:24];
    lim = neg_r ? (72'd1 << 47) : ((72'd1 << 47) - 72'd1);
    qs = (q > lim) ? lim : q;
    res_nxt = neg_r ? -$signed(qs[COV_W-1:0]) : $signed(qs[COV_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 3'd0;
      end else if (busy_r) begin
        if (ph_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        ph_r <= ph_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a_mag;
      b_r    <= b_mag;
      neg_r  <= neg;
      sh32_r <= sh32;
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      if (ph_r <= 3'd3) begin
        pp_r  <= 64'(a_part) * 64'(b_part);
        off_r <= 2'(ph_r[1]) + 2'(ph_r[0]);
      end
      if (ph_r == 3'd6) begin
        res_r <= res_nxt;
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

// ===== rtl/kabf_div.sv =====
`default_nettype none
module kabf_div
  import kabf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [COV_W-1:0]        n_mag,
  input  wire logic [COV_W-1:0]        d_mag,
  input  wire logic                    neg,
  output logic                         done,
  output logic signed [COV_W-1:0]      result
);

  logic [COV_W-1:0] n_r, d_r, rem_r;
  logic [COV_W-2:0] q_r;
  logic             over_r, neg_r, busy_r, done_r;
  logic [6:0]       cnt_r;
  logic [COV_W:0]   trial;
  logic             ge;
  logic [COV_W:0]   diff;
  logic [COV_W-1:0] q48;

  always_comb begin
    trial = {rem_r, n_r[COV_W-1]};
    ge    = trial >= {1'b0, d_r};
    diff  = trial - {1'b0, d_r};
    q48   = over_r ? {1'b0, {(COV_W-1){1'b1}}} : {1'b0, q_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 7'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n_mag;
      d_r    <= d_mag;
      neg_r  <= neg;
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
      cnt_r  <= 7'd79;
    end else if (busy_r) begin
      n_r   <= {n_r[COV_W-2:0], 1'b0};
      rem_r <= ge ? diff[COV_W-1:0] : trial[COV_W-1:0];
      q_r   <= {q_r[COV_W-3:0], ge};
      if (ge && cnt_r >= 7'd47) begin
        over_r <= 1'b1;
      end
      cnt_r <= cnt_r - 7'd1;
    end
  end

  assign done   = done_r;
  assign result = neg_r ? -$signed(q48) : $signed(q48);

endmodule
`default_nettype wire

// ===== rtl/kabf_dp.sv =====
`default_nettype none
module kabf_dp
  import kabf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic [95:0] in_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic [63:0]      out_tdata,
  output logic [0:0]       out_tuser
);

  logic [31:0] an_r, bn_r, mn_r;
  logic signed [VAL_W-1:0] ang_r, bias_r, meas_r;
  logic [31:0] dt_r;
  logic signed [32:0] rate_r, y_r;
  logic signed [COV_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [COV_W-1:0] t_r, inner_r, s_r, k0_r, k1_r, n0_r;
  logic sing_r;
  logic [63:0] odata_r;
  logic osing_r;

  logic signed [OPD_W-1:0] opa, opb;
  logic signed [COV_W-1:0] dnum, mres, dres;
  logic mul_done, div_done;
  logic signed [COV_W-1:0] s_nxt;
  logic signed [SUM_W-1:0] m52;

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      OP_ANG_P:  begin opa = {17'b0, dt_r}; opb = {{16{rate_r[32]}}, rate_r}; end
      OP_T:      begin opa = {17'b0, dt_r}; opb = {p11_r[47], p11_r}; end
      OP_P00:    begin opa = {17'b0, dt_r}; opb = {inner_r[47], inner_r}; end
      OP_P11:    begin opa = {17'b0, bn_r}; opb = {17'b0, dt_r}; end
      OP_ANG_C:  begin opa = {k0_r[47], k0_r}; opb = {{16{y_r[32]}}, y_r}; end
      OP_BIAS_C: begin opa = {k1_r[47], k1_r}; opb = {{16{y_r[32]}}, y_r}; end
      OP_N0:     begin opa = {k0_r[47], k0_r}; opb = {p00_r[47], p00_r}; end
      OP_P10C:   begin opa = {k1_r[47], k1_r}; opb = {p00_r[47], p00_r}; end
      OP_P11C:   begin opa = {k1_r[47], k1_r}; opb = {p01_r[47], p01_r}; end
      OP_P01C:   begin opa = {k0_r[47], k0_r}; opb = {p01_r[47], p01_r}; end
      default:   begin opa = '0; opb = '0; end
    endcase
    dnum  = (cmd.op == OP_K1) ? p10_r : p00_r;
    s_nxt = sat48(ext48(p00_r) + $signed({20'b0, mn_r}));
    m52   = ext48(mres);
  end

  kabf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start_mul),
    .a_mag  (mag49(opa)),
    .b_mag  (mag49(opb)),
    .neg    (opa[OPD_W-1] ^ opb[OPD_W-1]),
    .sh32   (cmd.op >= OP_ANG_C),
    .done   (mul_done),
    .result (mres)
  );

  kabf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start_div),
    .n_mag  (mag49({dnum[47], dnum})),
    .d_mag  (mag49({s_r[47], s_r})),
    .neg    (dnum[47] ^ s_r[47]),
    .done   (div_done),
    .result (dres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_r   <= ANGLE_NOISE_RST;
      bn_r   <= BIAS_NOISE_RST;
      mn_r   <= MEASURE_NOISE_RST;
      ang_r  <= '0;
      bias_r <= '0;
      p00_r  <= '0;
      p01_r  <= '0;
      p10_r  <= '0;
      p11_r  <= '0;
      sing_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_NOISE:   an_r <= cfg_data;
          REG_BIAS_NOISE:    bn_r <= cfg_data;
          REG_MEASURE_NOISE: mn_r <= cfg_data;
          default:           ;
        endcase
      end
      if (cmd.load) begin
        meas_r <= in_tdata[31:0];
        dt_r   <= in_tdata[95:64];
        rate_r <= {in_tdata[63], in_tdata[63:32]} - {bias_r[31], bias_r};
      end
      if (cmd.write) begin
        case (cmd.op)
          OP_ANG_P:  ang_r <= sat32(ext32(ang_r) + m52);
          OP_T:      t_r <= mres;
          OP_INNER:  inner_r <= sat48(ext48(t_r) - ext48(p01_r) - ext48(p10_r)
                                      + $signed({20'b0, an_r}));
          OP_P00: begin
            p00_r <= sat48(ext48(p00_r) + m52);
            p01_r <= sat48(ext48(p01_r) - ext48(t_r));
            p10_r <= sat48(ext48(p10_r) - ext48(t_r));
          end
          OP_P11:    p11_r <= sat48(ext48(p11_r) + m52);
          OP_S: begin
            s_r    <= s_nxt;
            sing_r <= (s_nxt == '0);
            y_r    <= {meas_r[31], meas_r} - {ang_r[31], ang_r};
          end
          OP_K0:     k0_r <= sing_r ? '0 : dres;
          OP_K1:     k1_r <= sing_r ? '0 : dres;
          OP_ANG_C:  ang_r <= sat32(ext32(ang_r) + m52);
          OP_BIAS_C: bias_r <= sat32(ext32(bias_r) + m52);
          OP_N0:     n0_r <= sat48(ext48(p00_r) - m52);
          OP_P10C: begin
            p10_r <= sat48(ext48(p10_r) - m52);
            p00_r <= n0_r;
          end
          OP_P11C:   p11_r <= sat48(ext48(p11_r) - m52);
          OP_P01C:   p01_r <= sat48(ext48(p01_r) - m52);
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= {bias_r, ang_r};
      osing_r <= sing_r;
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.singular = sing_r;
  assign out_tdata     = odata_r;
  assign out_tuser     = osing_r;

endmodule
`default_nettype wire

// ===== rtl/kabf_ctrl.sv =====
`default_nettype none
module kabf_ctrl
  import kabf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  state_t st_r;
  op_t    op_r;
  logic   out_valid_r;
  logic   step_end;
  kind_t  kind;

  always_comb begin
    kind          = op_kind(op_r);
    cmd           = '0;
    cmd.op        = op_r;
    in_tready     = 1'b0;
    step_end      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_ISSUE: begin
        if (kind == KIND_ALU || (kind == KIND_DIV && stat.singular)) begin
          cmd.write = 1'b1;
          step_end  = 1'b1;
        end else if (kind == KIND_DIV) begin
          cmd.start_div = 1'b1;
        end else begin
          cmd.start_mul = 1'b1;
        end
      end
      ST_WAIT: begin
        if (stat.mul_done || stat.div_done) begin
          cmd.write = 1'b1;
          step_end  = 1'b1;
        end
      end
      ST_OUT: begin
        cmd.out_load = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      op_r        <= OP_ANG_P;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            st_r <= ST_ISSUE;
            op_r <= OP_ANG_P;
          end
        end
        ST_ISSUE: begin
          if (step_end) begin
            if (op_r == OP_P01C) begin
              st_r <= ST_OUT;
            end else begin
              op_r <= op_t'(op_r + 4'd1);
            end
          end else begin
            st_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (step_end) begin
            if (op_r == OP_P01C) begin
              st_r <= ST_OUT;
            end else begin
              st_r <= ST_ISSUE;
              op_r <= op_t'(op_r + 4'd1);
            end
          end
        end
        ST_OUT: begin
          if (cmd.out_load) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/kabf_checker.sv =====
`default_nettype none
module kabf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after a transfer");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== verif/kalman_angle_bias_filter_tb.sv =====
`timescale 1ns / 100ps
module kalman_angle_bias_filter_tb;
  import kabf_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 400;

  typedef struct {
    logic [31:0] angle;
    logic [31:0] bias;
    logic        singular;
  } estimate_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // meas_angle, gyro_rate, time_step
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // filtered_angle, rate_bias
  logic [0:0]  out_tuser;       // singular_flag
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  estimate_t   pending_estimates[$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;

  logic [31:0] angle_noise_q, bias_noise_q, measure_noise_q;
  longint      angle_est, bias_est;
  longint      cov[4];

  kalman_angle_bias_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint clamp(input longint v, input int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint scaled_product(input longint a, input longint b, input int sh);
    logic [127:0] p;
    logic [63:0]  ua, ub, lim;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'b0, ua} * {64'b0, ub};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    lim = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
    if (p > {64'b0, lim}) p = {64'b0, lim};
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint kalman_gain(input longint num, input longint den);
    logic [127:0] q;
    logic [63:0]  n, d;
    bit           neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = {32'b0, n, 32'b0} / {64'b0, d};
    if (q > (128'd1 << 47) - 1) q = (128'd1 << 47) - 1;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic estimate_t filter_step(input logic [31:0] meas, input logic [31:0] gyro,
                                            input logic [31:0] dt_bits);
    estimate_t r;
    longint dt, rate, t, inner, s, k0, k1, y, p00, p01, p10, p11;
    dt = longint'({32'b0, dt_bits});
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    k0 = 0; k1 = 0;
    r.singular = 1'b0;
    rate = longint'(signed'(gyro)) - bias_est;
    angle_est = clamp(angle_est + scaled_product(dt, rate, 24), 32);
    t = scaled_product(dt, p11, 24);
    inner = clamp(t - p01 - p10 + longint'({32'b0, angle_noise_q}), 48);
    p00 = clamp(p00 + scaled_product(dt, inner, 24), 48);
    p01 = clamp(p01 - t, 48);
    p10 = clamp(p10 - t, 48);
    p11 = clamp(p11 + scaled_product(longint'({32'b0, bias_noise_q}), dt, 24), 48);
    s = clamp(p00 + longint'({32'b0, measure_noise_q}), 48);
    if (s == 0) begin
      r.singular = 1'b1;
    end else begin
      k0 = kalman_gain(p00, s);
      k1 = kalman_gain(p10, s);
    end
    y = longint'(signed'(meas)) - angle_est;
    angle_est = clamp(angle_est + scaled_product(k0, y, 32), 32);
    bias_est = clamp(bias_est + scaled_product(k1, y, 32), 32);
    cov[0] = clamp(p00 - scaled_product(k0, p00, 32), 48);
    cov[1] = clamp(p01 - scaled_product(k0, p01, 32), 48);
    cov[2] = clamp(p10 - scaled_product(k1, p00, 32), 48);
    cov[3] = clamp(p11 - scaled_product(k1, p01, 32), 48);
    r.angle = angle_est[31:0];
    r.bias = bias_est[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    estimate_t e;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[kalman_angle_bias_filter] ERROR");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (pending_estimates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transfer: %h", out_tdata);
        end else begin
          e = pending_estimates.pop_front();
          if (out_tdata[31:0] !== e.angle || out_tdata[63:32] !== e.bias ||
              out_tuser[0] !== e.singular) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected angle %h bias %h flag %b, got angle %h bias %h flag %b",
                       e.angle, e.bias, e.singular, out_tdata[31:0], out_tdata[63:32],
                       out_tuser[0]);
            end
          end
        end
      end
    end
  end

  task automatic send_sample(input logic [31:0] meas, input logic [31:0] gyro,
                             input logic [31:0] dt);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {dt, gyro, meas};
    do @(posedge clk); while (!in_tready);
    pending_estimates.push_back(filter_step(meas, gyro, dt));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_ANGLE_NOISE:   angle_noise_q = value;
      REG_BIAS_NOISE:    bias_noise_q = value;
      REG_MEASURE_NOISE: measure_noise_q = value;
      default: ;
    endcase
  endtask

  task automatic set_noises(input logic [31:0] an, input logic [31:0] bn,
                            input logic [31:0] mn);
    drain();
    write_reg(REG_ANGLE_NOISE, an);
    write_reg(REG_BIAS_NOISE, bn);
    write_reg(REG_MEASURE_NOISE, mn);
    cfg_we <= 1'b0;
  endtask

  task automatic test_extremes();
    send_sample(32'h7FFF_FFFF, 32'h0000_0000, 32'h0100_0000);
    send_sample(32'h8000_0000, 32'h0000_0000, 32'h0100_0000);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h0001_0000, 32'h0000_8000, 32'h0000_0000);
    send_sample(32'hFFFF_0000, 32'hFFFF_8000, 32'h0004_0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
  endtask

  // With zero noise, zero covariance and no elapsed time the innovation
  // variance is zero, so both gains are forced to zero.
  task automatic test_singular();
    set_noises(32'h0, 32'h0, 32'h0);
    reset_model_cov();
    send_sample(32'h0005_0000, 32'h0001_0000, 32'h0000_0000);
    send_sample(32'hFFFB_0000, 32'h0002_0000, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_sample(32'h0003_0000, 32'h0000_0000, 32'h0010_0000);
  endtask

  task automatic reset_model_cov();
    // The filter is only singular from here when the covariance is zero.
    if (cov[0] != 0 || cov[1] != 0 || cov[2] != 0 || cov[3] != 0) begin
      send_sample(32'h0, 32'h0, 32'h0);
    end
  endtask

  task automatic test_random_run(input int count, input int s_idle, input int r_idle);
    logic [31:0] meas, gyro, dt;
    sender_idle_pct = s_idle;
    receiver_idle_pct = r_idle;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) begin
        meas = $urandom_range(0, 32'h00B4_0000) - 32'h005A_0000;
        gyro = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        dt = $urandom_range(0, 32'h0020_0000);
      end else begin
        meas = $urandom;
        gyro = $urandom;
        dt = $urandom;
      end
      send_sample(meas, gyro, dt);
      if (i == count / 2 && s_idle == 0) drain();
    end
  endtask

  initial begin
    angle_noise_q = ANGLE_NOISE_RST;
    bias_noise_q = BIAS_NOISE_RST;
    measure_noise_q = MEASURE_NOISE_RST;
    angle_est = 0;
    bias_est = 0;
    for (int i = 0; i < 4; i++) cov[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 32;
    receiver_idle_pct = 83;
    test_extremes();
    test_singular();
    set_noises(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST);
    test_random_run(260, 32, 83);
    set_noises(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random_run(260, 83, 32);
    set_noises($urandom, $urandom, $urandom_range(1, 32'h1000_0000));
    test_random_run(260, 0, 0);
    drain();
    if (mismatches == 0) begin
      $display("[kalman_angle_bias_filter] OK");
    end else begin
      $display("[kalman_angle_bias_filter] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kabf_pkg.sv
rtl/kabf_mul.sv
rtl/kabf_div.sv
rtl/kabf_dp.sv
rtl/kabf_ctrl.sv
rtl/kalman_angle_bias_filter.sv
rtl/kabf_checker.sv
verif/kalman_angle_bias_filter_tb.sv
